>>> hw/rtl/met_pkg.sv
// Shared types, constants and helpers of the Mandelbrot escape test core.
// Holds the request payload structs, the sequencer states and the Q8.24 saturation helpers.
// No dependencies.
package met_pkg;

  // number range and fixed point format
  localparam int unsigned MaxIterations    = 50;
  localparam int unsigned IterW            = $clog2(MaxIterations + 1);
  localparam int unsigned FracBits         = 24;
  localparam int unsigned ScreenHeightLog2 = 6;
  localparam int unsigned ColW             = 7;
  localparam int unsigned RowW             = 6;
  localparam int unsigned DataW            = 32;
  localparam int unsigned AddrW            = 4;

  // saturation bounds of Q8.24 held in 64 bits
  localparam logic signed [63:0] QMax64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] QMin64 = 64'shFFFF_FFFF_8000_0000;

  // escape bound 4.0 in Q8.24, one bit wider than a register
  localparam logic signed [32:0] EscapeLimit = 33'sh0_0400_0000;

  // register reset values
  localparam logic signed [31:0] XZoomReset   = 32'sd41439724;
  localparam logic signed [31:0] YZoomReset   = 32'sd37580964;
  localparam logic signed [31:0] XOffsetReset = 32'sd50331648;
  localparam logic signed [31:0] YOffsetReset = 32'sd18790482;

  // register indexes (word address paddr[3:2])
  localparam logic [1:0] RegXZoom   = 2'd0;
  localparam logic [1:0] RegYZoom   = 2'd1;
  localparam logic [1:0] RegXOffset = 2'd2;
  localparam logic [1:0] RegYOffset = 2'd3;

  // input request payload
  typedef struct packed {
    logic [ColW-1:0] pixel_col;
    logic [RowW-1:0] pixel_row;
  } met_in_t;

  // result request payload
  typedef struct packed {
    logic            inside_set;
    logic [ColW-1:0] col_echo;
    logic [RowW-1:0] row_echo;
  } met_out_t;

  // sequencer states
  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StMapX = 9'b000000010,
    StMapY = 9'b000000100,
    StMapC = 9'b000001000,
    StTest = 9'b000010000,
    StZi   = 9'b000100000,
    StSr   = 9'b001000000,
    StSi   = 9'b010000000,
    StDone = 9'b100000000
  } met_state_e;

  // sign extend a Q8.24 value to 64 bits
  function automatic logic signed [63:0] sext64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // clamp a 64-bit value to the Q8.24 range
  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > QMax64) begin
      r = QMax64[31:0];
    end else if (v < QMin64) begin
      r = QMin64[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/mandelbrot_escape_test_core.sv
// Mandelbrot escape test core: maps a pixel to a complex point and iterates z = z*z + c.
// Depends on met_pkg for payload types, sequencer states and saturation helpers.
//
// Usage
//   in channel : valid/ready request carrying pixel_col and pixel_row. in_ready_o is high
//                only while the sequencer is idle; one pixel is worked on at a time.
//   out channel: valid/ready request carrying inside_set and the echoed column and row,
//                held in an output register so a new pixel is taken while it waits.
//   APB port   : four 32-bit Q8.24 registers (x_zoom, y_zoom, x_offset, y_offset) at
//                byte addresses 0, 4, 8, 12; write them only while the core is idle.
// Sequence
//   one signed 32x32 multiplier, product registered, shared by the mapping and orbit steps.
//   mapping (map x, map y, map c), then per iteration the escape test issuing zr*zi and updating
//   zr, zi issuing zr*zr, sr issuing zi*zi, and si; then a final escape test and a result hand-off.
//   a point inside the set runs all 50 iterations. a new pixel is accepted only back in idle,
//   once the previous result has gone into the output register.
// Reset and stall
//   reset returns to idle, clears the output valid flag and loads the default view.
//   if the result register is still full when a pixel finishes, the core waits in its
//   last state until out_ready_i frees it; no result is lost or dropped.
module mandelbrot_escape_test_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // pixel requests
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  met_pkg::met_in_t        in_data_i,
  // result requests
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output met_pkg::met_out_t       out_data_o,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [met_pkg::AddrW-1:0] paddr,
  input  logic [met_pkg::DataW-1:0] pwdata,
  output logic [met_pkg::DataW-1:0] prdata,
  output logic                    pready
);
  import met_pkg::*;

  met_state_e state_q, state_d;

  logic signed [31:0] x_zoom_q, y_zoom_q, x_offset_q, y_offset_q;
  logic [ColW-1:0]    col_q;
  logic [RowW-1:0]    row_q;
  logic signed [31:0] cr_q, ci_q, zr_q, zi_q, sr_q, si_q;
  logic [IterW-1:0]   iter_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [32:0] esc_sum;
  logic               keep_going;
  logic               out_free;
  logic               out_valid_q;
  met_out_t           out_data_q;
  logic               cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_zoom_q   <= XZoomReset;
      y_zoom_q   <= YZoomReset;
      x_offset_q <= XOffsetReset;
      y_offset_q <= YOffsetReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegXZoom:   x_zoom_q   <= pwdata;
        RegYZoom:   y_zoom_q   <= pwdata;
        RegXOffset: x_offset_q <= pwdata;
        RegYOffset: y_offset_q <= pwdata;
        default:    x_zoom_q   <= x_zoom_q;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      RegXZoom:   prdata = x_zoom_q;
      RegYZoom:   prdata = y_zoom_q;
      RegXOffset: prdata = x_offset_q;
      RegYOffset: prdata = y_offset_q;
      default:    prdata = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      StMapX: begin
        mul_a = {{(32-ColW){1'b0}}, col_q};
        mul_b = x_zoom_q;
      end
      StMapY: begin
        mul_a = {{(32-RowW){1'b0}}, row_q};
        mul_b = y_zoom_q;
      end
      StZi: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      StSr: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  // signed 32x32 product, sign extended operands
  assign mul_p = sext64(mul_a) * sext64(mul_b);

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
  end

  // escape test and iteration limit
  assign esc_sum    = {sr_q[31], sr_q} + {si_q[31], si_q};
  assign keep_going = (esc_sum <= EscapeLimit) && (iter_q < IterW'(MaxIterations));
  assign out_free   = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StMapX;
      StMapX: state_d = StMapY;
      StMapY: state_d = StMapC;
      StMapC: state_d = StTest;
      StTest: state_d = keep_going ? StZi : StDone;
      StZi:   state_d = StSr;
      StSr:   state_d = StSi;
      StSi:   state_d = StTest;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (state_q == StMapC) begin
      iter_q <= '0;
    end else if (state_q == StSi) begin
      iter_q <= iter_q + IterW'(1);
    end
  end

  // point and orbit datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        col_q <= in_data_i.pixel_col;
        row_q <= in_data_i.pixel_row;
      end
      StMapY: cr_q <= sat_q((prod_q >>> ScreenHeightLog2) - sext64(x_offset_q));
      StMapC: begin
        ci_q <= sat_q((prod_q >>> ScreenHeightLog2) - sext64(y_offset_q));
        zr_q <= '0;
        zi_q <= '0;
        sr_q <= '0;
        si_q <= '0;
      end
      // zr*zi is issued this cycle from the old zr, so zr can move on now
      StTest: if (keep_going) zr_q <= sat_q(sext64(sr_q) - sext64(si_q) + sext64(cr_q));
      StZi:   zi_q <= sat_q((prod_q >>> (FracBits - 1)) + sext64(ci_q));
      StSr:   sr_q <= sat_q(prod_q >>> FracBits);
      StSi:   si_q <= sat_q(prod_q >>> FracBits);
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      out_data_q.inside_set <= (iter_q >= IterW'(MaxIterations));
      out_data_q.col_echo   <= col_q;
      out_data_q.row_echo   <= row_q;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_accept_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StMapX)
    else $error("accepted pixel did not start mapping");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= IterW'(MaxIterations))
    else $error("iteration count beyond limit");

  a_limit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StTest && iter_q == IterW'(MaxIterations) |=> state_q == StDone)
    else $error("iteration continued past limit");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone && out_valid_q && !out_ready_i |=> state_q == StDone && out_valid_q)
    else $error("result overwrote a pending result");

endmodule
